[rtl/rbt_pkg.sv]
// Shared types, constants and helper functions of the reconnect backoff table.
// Depends on nothing; the top level of the block imports it.
package rbt_pkg;

  localparam int unsigned PEER_SLOTS      = 16;
  localparam int unsigned MAX_INTERVALS   = 4;
  localparam int unsigned RESULT_LIMIT    = 16;
  localparam int unsigned DEFAULT_DELAY_S = 30;
  localparam int unsigned MS_PER_S        = 1000;

  localparam int unsigned TIME_W     = 40;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned OUTCOME_W  = 2;
  localparam int unsigned STATUS_W   = 4;
  localparam int unsigned ATT_W      = 8;
  localparam int unsigned QSIZE_W    = 5;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned DELAY_MS_W = 26;
  localparam int unsigned IVL_IDX_W  = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_SCHEDULE = 3'd0,
    KIND_MARK     = 3'd1,
    KIND_POLL     = 3'd2,
    KIND_OUTCOME  = 3'd3,
    KIND_REMOVE   = 3'd4,
    KIND_CLEAR    = 3'd5
  } kind_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_ALREADY    = 2'd0,
    OUT_PEER_LIMIT = 2'd1,
    OUT_CONNECTED  = 2'd2,
    OUT_FAILED     = 2'd3
  } outcome_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_SCHEDULED   = 4'd0,
    STS_INACTIVE    = 4'd1,
    STS_SUPPRESSED  = 4'd2,
    STS_ALREADY     = 4'd3,
    STS_MARKED      = 4'd4,
    STS_DUE         = 4'd5,
    STS_NONE_DUE    = 4'd6,
    STS_RECONNECTED = 4'd7,
    STS_NOT_QUEUED  = 4'd8,
    STS_SKIPPED     = 4'd9,
    STS_RESCHEDULED = 4'd10,
    STS_DROPPED     = 4'd11,
    STS_CLEARED     = 4'd12,
    STS_REMOVED     = 4'd13
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECONNECT_ENABLED = 3'd0,
    CFG_CLIENT_RUNNING    = 3'd1,
    CFG_STABLE_THRESHOLD  = 3'd2,
    CFG_STABLE_FIRST      = 3'd3,
    CFG_ATTEMPT_LIMIT     = 3'd4,
    CFG_INTERVAL_COUNT    = 3'd5,
    CFG_INTERVALS_PACKED  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [SLOT_W-1:0]    peer_slot;
    logic [TIME_W-1:0]    time_ms;
    logic [TIME_W-1:0]    connect_start_ms;
    logic [OUTCOME_W-1:0] outcome;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
    logic [ATT_W-1:0]    attempts;
    logic [QSIZE_W-1:0]  queue_size;
    logic                last;
  } res_t;

  typedef struct packed {
    logic [TIME_W-1:0] deadline_ms;
    logic              stable;
    logic [ATT_W-1:0]  attempts;
  } entry_t;

  function automatic logic [DELAY_W-1:0] delay_sel(
    input logic [ATT_W-1:0]      att,
    input logic                  stable,
    input logic [DELAY_W-1:0]    first_s,
    input logic [CFG_IDX_W-1:0]  count,
    input logic [CFG_DATA_W-1:0] ivl_word
  );
    logic [CFG_IDX_W-1:0] n;
    logic [ATT_W-1:0]     idx;
    logic [DELAY_W-1:0]   d;
    n   = (count > CFG_IDX_W'(MAX_INTERVALS)) ? CFG_IDX_W'(MAX_INTERVALS) : count;
    idx = '0;
    if (att == '0 && stable) begin
      d = first_s;
    end else if (n == '0) begin
      d = DELAY_W'(DEFAULT_DELAY_S);
    end else begin
      idx = (att < ATT_W'(n)) ? att : ATT_W'(n - CFG_IDX_W'(1));
      d   = ivl_word[{idx[IVL_IDX_W-1:0], 4'd0} +: DELAY_W];
    end
    return d;
  endfunction

  function automatic logic [TIME_W-1:0] deadline_sum(
    input logic [TIME_W-1:0]     now,
    input logic [DELAY_MS_W-1:0] delay_ms
  );
    logic [TIME_W:0] s;
    s = {1'b0, now} + (TIME_W+1)'(delay_ms);
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

endpackage

[rtl/rbt_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; holds the per-slot entries of the backoff table.
module rbt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/reconnect_backoff_table_unit.sv]
// Top level of the reconnect backoff table: control sequencer, flag bits and poll scan.
// Depends on rbt_pkg and on rbt_ram, which holds deadline, stable flag and attempts.
//
// A request is taken at a rising edge with start high and busy low; its fields arrive
// on req_i. Each result appears on res_o for exactly one cycle, marked by res_strobe_o,
// and the final result of a request carries last. The receiver cannot stall, so results
// are never held back. Schedule, mark, outcome, remove and clear requests, and polls
// while inactive, read the slot entry, compute the deadline in three register stages
// RD, MUL and WR, and give one registered result; busy is high through these stages.
// Requests of an unused kind give no result. An active poll sweeps the entry RAM one
// slot per cycle, stopping at RESULT_LIMIT due results; due results stream out during
// the sweep, the last one when busy falls. The single read port of the entry RAM sets
// the length of the sweep. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must do so only while busy is low, which the block does not
// enforce. Reset clears all valid, mark and attempt bits at once; no clearing pass is
// needed, and a request can be taken in the first cycle after reset.
module reconnect_backoff_table_unit import rbt_pkg::*; #(
  parameter int unsigned PeerSlots = PEER_SLOTS,
  localparam int unsigned SlotW = (PeerSlots > 1) ? $clog2(PeerSlots) : 1,
  localparam int unsigned CntW  = $clog2(PeerSlots + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  output logic                  res_strobe_o,
  output res_t                  res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0] state_q, state_d;

  logic                  enabled_q, running_q;
  logic [DELAY_W-1:0]    thr_q, first_q;
  logic [ATT_W-1:0]      limit_q;
  logic [CFG_IDX_W-1:0]  ivl_cnt_q;
  logic [CFG_DATA_W-1:0] ivl_word_q;

  logic [PeerSlots-1:0] valid_q, valid_d;
  logic [PeerSlots-1:0] mark_q, mark_d;
  logic [PeerSlots-1:0] att_ok_q, att_ok_d;
  logic [CntW-1:0]      count_q, count_d;

  req_t                  req_q;
  entry_t                ent_q;
  logic [TIME_W-1:0]     dur_q, dur_d;
  logic [DELAY_MS_W-1:0] thr_ms_q, thr_ms_d;
  logic [ATT_W-1:0]      att_cur_q, att_cur_d;
  logic [ATT_W-1:0]      att_new_q, att_new_d;
  logic                  stable_q, stable_d;
  logic [DELAY_MS_W-1:0] delay_ms_q, delay_ms_d;

  logic [CntW-1:0]    rd_idx_q, rd_idx_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [SlotW-1:0]   cmp_idx_q, cmp_idx_d;
  logic [QSIZE_W-1:0] found_q, found_d;
  logic               pend_vld_q, pend_vld_d;
  res_t               pend_q, pend_d;

  logic res_strobe_q, res_strobe_d;
  res_t res_q, res_d;

  logic             accept, active, in_range, issuing, due;
  logic [SlotW-1:0] slot_idx, ram_raddr;
  logic             ram_we;
  entry_t           ram_wdata, ram_rdata;
  logic [TIME_W-1:0] deadline;
  res_t             wr_res, cur_res;
  logic             cur_valid, cur_mark;

  assign accept   = start && (state_q == S_IDLE);
  assign busy     = (state_q != S_IDLE);
  assign active   = enabled_q && running_q;
  assign slot_idx = SlotW'(req_q.peer_slot);
  assign in_range = (32'(req_q.peer_slot) < PeerSlots);
  assign cur_valid = valid_q[slot_idx];
  assign cur_mark  = mark_q[slot_idx];
  assign ram_raddr = (state_q == S_SCAN) ? rd_idx_q[SlotW-1:0] : SlotW'(req_i.peer_slot);

  rbt_ram #(
    .Width($bits(entry_t)),
    .Depth(PeerSlots)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_idx),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b1;
      running_q  <= 1'b1;
      thr_q      <= DELAY_W'(60);
      first_q    <= DELAY_W'(2);
      limit_q    <= ATT_W'(10);
      ivl_cnt_q  <= CFG_IDX_W'(4);
      ivl_word_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RECONNECT_ENABLED: enabled_q  <= cfg_data_i[0];
        CFG_CLIENT_RUNNING:    running_q  <= cfg_data_i[0];
        CFG_STABLE_THRESHOLD:  thr_q      <= cfg_data_i[DELAY_W-1:0];
        CFG_STABLE_FIRST:      first_q    <= cfg_data_i[DELAY_W-1:0];
        CFG_ATTEMPT_LIMIT:     limit_q    <= cfg_data_i[ATT_W-1:0];
        CFG_INTERVAL_COUNT:    ivl_cnt_q  <= cfg_data_i[CFG_IDX_W-1:0];
        CFG_INTERVALS_PACKED:  ivl_word_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    dur_d    = (req_q.time_ms >= req_q.connect_start_ms) ?
               (req_q.time_ms - req_q.connect_start_ms) : '0;
    thr_ms_d = DELAY_MS_W'(thr_q) * DELAY_MS_W'(MS_PER_S);
  end

  always_comb begin
    logic [ATT_W-1:0] att_sel;
    att_cur_d = att_ok_q[slot_idx] ? ent_q.attempts : '0;
    att_new_d = (att_cur_d == '1) ? att_cur_d : att_cur_d + ATT_W'(1);
    stable_d  = (req_q.kind == KIND_SCHEDULE) ? (dur_q >= TIME_W'(thr_ms_q)) : ent_q.stable;
    att_sel   = (req_q.kind == KIND_SCHEDULE) ? '0 : att_new_d;
    delay_ms_d = DELAY_MS_W'(delay_sel(att_sel, stable_d, first_q, ivl_cnt_q, ivl_word_q))
                 * DELAY_MS_W'(MS_PER_S);
  end

  assign deadline = deadline_sum(req_q.time_ms, delay_ms_q);

  always_comb begin
    valid_d   = valid_q;
    mark_d    = mark_q;
    att_ok_d  = att_ok_q;
    count_d   = count_q;
    ram_we    = 1'b0;
    ram_wdata = '{deadline_ms: deadline, stable: stable_q, attempts: att_new_q};
    wr_res    = '{slot: req_q.peer_slot, status: STS_NOT_QUEUED, attempts: att_cur_q,
                  queue_size: '0, last: 1'b1};
    if (req_q.kind == KIND_POLL) begin
      wr_res.slot     = '0;
      wr_res.status   = STS_INACTIVE;
      wr_res.attempts = '0;
    end else if (req_q.kind == KIND_CLEAR) begin
      valid_d  = '0;
      mark_d   = '0;
      att_ok_d = '0;
      count_d  = '0;
      wr_res.slot     = '0;
      wr_res.status   = STS_CLEARED;
      wr_res.attempts = '0;
    end else if (!in_range) begin
      wr_res.attempts = '0;
    end else if (req_q.kind == KIND_SCHEDULE) begin
      if (!active) begin
        wr_res.status = STS_INACTIVE;
      end else if (cur_mark) begin
        mark_d[slot_idx] = 1'b0;
        wr_res.status    = STS_SUPPRESSED;
      end else if (cur_valid) begin
        wr_res.status = STS_ALREADY;
      end else begin
        valid_d[slot_idx]  = 1'b1;
        att_ok_d[slot_idx] = 1'b1;
        count_d            = count_q + CntW'(1);
        ram_we             = 1'b1;
        ram_wdata.attempts = '0;
        wr_res.status      = STS_SCHEDULED;
        wr_res.attempts    = '0;
      end
    end else if (req_q.kind == KIND_MARK) begin
      mark_d[slot_idx] = 1'b1;
      wr_res.status    = STS_MARKED;
    end else if (!cur_valid) begin
      wr_res.status = STS_NOT_QUEUED;
    end else if (req_q.kind == KIND_REMOVE) begin
      valid_d[slot_idx] = 1'b0;
      count_d           = count_q - CntW'(1);
      wr_res.status     = STS_REMOVED;
    end else if (req_q.outcome == OUT_ALREADY || req_q.outcome == OUT_CONNECTED) begin
      valid_d[slot_idx] = 1'b0;
      count_d           = count_q - CntW'(1);
      wr_res.status     = STS_RECONNECTED;
    end else if (req_q.outcome == OUT_PEER_LIMIT) begin
      wr_res.status = STS_SKIPPED;
    end else begin
      ram_we          = 1'b1;
      wr_res.attempts = att_new_q;
      if (att_new_q >= limit_q) begin
        valid_d[slot_idx] = 1'b0;
        count_d           = count_q - CntW'(1);
        wr_res.status     = STS_DROPPED;
      end else begin
        wr_res.status = STS_RESCHEDULED;
      end
    end
    wr_res.queue_size = QSIZE_W'(count_d);
    if (state_q != S_WR) begin
      valid_d  = valid_q;
      mark_d   = mark_q;
      att_ok_d = att_ok_q;
      count_d  = count_q;
      ram_we   = 1'b0;
    end
  end

  assign issuing = (state_q == S_SCAN) && (rd_idx_q < CntW'(PeerSlots)) &&
                   (found_q < QSIZE_W'(RESULT_LIMIT));
  assign due     = (state_q == S_SCAN) && cmp_vld_q && valid_q[cmp_idx_q] &&
                   (req_q.time_ms >= ram_rdata.deadline_ms) &&
                   (found_q < QSIZE_W'(RESULT_LIMIT));

  always_comb begin
    cur_res = '{slot: SLOT_W'(cmp_idx_q), status: STS_DUE,
                attempts: att_ok_q[cmp_idx_q] ? ram_rdata.attempts : '0,
                queue_size: QSIZE_W'(count_q), last: 1'b0};
  end

  always_comb begin
    state_d      = state_q;
    rd_idx_d     = rd_idx_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = rd_idx_q[SlotW-1:0];
    found_d      = found_q;
    pend_vld_d   = pend_vld_q;
    pend_d       = pend_q;
    res_strobe_d = 1'b0;
    res_d        = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rd_idx_d   = '0;
          found_d    = '0;
          pend_vld_d = 1'b0;
          if (req_i.kind > KIND_CLEAR) begin
            state_d = S_IDLE;
          end else if (req_i.kind == KIND_POLL && active) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD:  state_d = S_MUL;
      S_MUL: state_d = S_WR;
      S_WR: begin
        res_strobe_d = 1'b1;
        res_d        = wr_res;
        state_d      = S_IDLE;
      end
      S_SCAN: begin
        cmp_vld_d = issuing;
        if (issuing) begin
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        if (due) begin
          if (pend_vld_q) begin
            res_strobe_d = 1'b1;
            res_d        = pend_q;
          end
          pend_d     = cur_res;
          pend_vld_d = 1'b1;
          found_d    = found_q + QSIZE_W'(1);
        end
        if (!issuing || found_d == QSIZE_W'(RESULT_LIMIT)) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        res_strobe_d = 1'b1;
        if (pend_vld_q) begin
          res_d      = pend_q;
          res_d.last = 1'b1;
        end else begin
          res_d = '{slot: '0, status: STS_NONE_DUE, attempts: '0,
                    queue_size: QSIZE_W'(count_q), last: 1'b1};
        end
        pend_vld_d = 1'b0;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      mark_q       <= '0;
      att_ok_q     <= '0;
      count_q      <= '0;
      rd_idx_q     <= '0;
      cmp_vld_q    <= 1'b0;
      found_q      <= '0;
      pend_vld_q   <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      mark_q       <= mark_d;
      att_ok_q     <= att_ok_d;
      count_q      <= count_d;
      rd_idx_q     <= rd_idx_d;
      cmp_vld_q    <= cmp_vld_d;
      found_q      <= found_d;
      pend_vld_q   <= pend_vld_d;
      res_strobe_q <= res_strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (state_q == S_RD) begin
      ent_q    <= ram_rdata;
      dur_q    <= dur_d;
      thr_ms_q <= thr_ms_d;
    end
    if (state_q == S_MUL) begin
      att_cur_q  <= att_cur_d;
      att_new_q  <= att_new_d;
      stable_q   <= stable_d;
      delay_ms_q <= delay_ms_d;
    end
    cmp_idx_q <= cmp_idx_d;
    pend_q    <= pend_d;
    res_q     <= res_d;
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CntW'($countones(valid_q)))
    else $error("queue count differs from the number of valid entries");

  a_single_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.kind == KIND_SCHEDULE) |-> ##4 (res_strobe_o && res_o.last))
    else $error("schedule request did not complete with a final result");

  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (state_q == S_SCAN || state_q == S_FLUSH))
    else $error("held poll result outside a sweep");

  a_found_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q <= QSIZE_W'(RESULT_LIMIT))
    else $error("poll found more results than allowed");

endmodule
